### hw/rtl/sgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_pkg - shared types and constants of the sequential group detector
// Configuration and result records, register indexes and count limits.
// ----------------------------------------------------------------------------
package sgd_pkg;

    localparam int BLOCK_W = 32;
    localparam int GROUP_W = 27;
    localparam int CNT_W   = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_WATER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WATER = 2'd2;

    // register reset values
    localparam logic [8:0] CAPACITY_RST   = 9'd256;
    localparam logic [7:0] LOW_WATER_RST  = 8'd0;
    localparam logic [8:0] HIGH_WATER_RST = 9'd64;

    typedef struct packed {
        logic [8:0] capacity;
        logic [7:0] low_water;
        logic [8:0] high_water;
    } cfg_t;

    typedef struct packed {
        logic               hit;
        logic               sequential_detected;
        logic [GROUP_W-1:0] group_number;
        logic [CNT_W-1:0]   groups_evicted;
        logic [CNT_W-1:0]   dirty_blocks_destaged;
    } result_t;

endpackage
`default_nettype wire

### hw/rtl/sgd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_ram - single-port-write, single-port-read synchronous RAM
// Words are split into lanes with a write enable each; read data registered.
// ----------------------------------------------------------------------------
module sgd_ram #(
    parameter int DEPTH  = 256,
    parameter int LANES  = 1,
    parameter int LANE_W = 8
) (
    input  wire logic                              clk,
    input  wire logic [LANES-1:0]                  we,
    input  wire logic [$clog2(DEPTH)-1:0]          waddr,
    input  wire logic [LANES*LANE_W-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]          raddr,
    output      logic [LANES*LANE_W-1:0]           rdata
);

    logic [LANES*LANE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (we[l])
            begin
                mem[waddr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
            end
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/sgd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_ctrl - group table sequencer
// Scans the entry RAM for the group, keeps recency as a linked list in the
// link RAM and runs hit, eviction, insert and sequential drop steps.
// ----------------------------------------------------------------------------
module sgd_ctrl #(
    parameter int BLOCKS_PER_GROUP = 32,
    parameter int TABLE_GROUPS     = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sgd_pkg::cfg_t     cfg,
    input  wire logic              start,
    input  wire logic [31:0]       blk,
    input  wire logic              rd,
    output      logic              busy,
    output      logic              res_valid,
    input  wire logic              res_ready,
    output      sgd_pkg::result_t  res
);

    localparam int B   = BLOCKS_PER_GROUP;
    localparam int OW  = $clog2(B);
    localparam int TW  = $clog2(64'hFFFF_FFFF / B + 1);
    localparam int IW  = $clog2(TABLE_GROUPS);
    localparam int PW  = IW + 1;
    localparam int EW  = 1 + TW + 2 * B;
    localparam int SH  = 32 + OW;
    localparam int PRW = SH + 32;

    localparam logic [63:0]   RECIP64  = (64'd1 << SH) / B;
    localparam logic [32:0]   RECIP    = RECIP64[32:0];
    localparam logic [31:0]   BPG32    = 32'(B);
    localparam logic [8:0]    BPG9     = 9'(B);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_GROUPS - 1);
    localparam logic [OW-1:0] LAST_OFF = OW'(B - 1);
    localparam logic [B-1:0]  FULL     = {B{1'b1}};
    localparam logic [PW-1:0] NIL_PTR  = {1'b1, {IW{1'b0}}};

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DIV, S_QUO, S_SCAN, S_SCAN_END, S_DECIDE,
        S_UL_RD, S_UL_PREV, S_UL_NEXT, S_PUSH_SELF, S_PUSH_HEAD,
        S_MISS, S_EV_CHECK, S_EV_RD, S_EV_POP, S_EV_ACC, S_ALLOC,
        S_INSERT, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_HIT, PH_MISS, PH_NEW, PH_DROP
    } phase_t;

    function automatic logic [6:0] popcnt(input logic [B-1:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < B; i++)
        begin
            n = n + 7'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [8:0] sat9(input logic [8:0] a, input logic [8:0] b);
        logic [9:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[9] ? sgd_pkg::CNT_MAX : s[8:0];
    endfunction

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [31:0]       blk_reg, blk_next;
    logic              rd_reg, rd_next;
    logic [PRW-1:0]    prod_reg, prod_next;
    logic [TW-1:0]     grp_reg, grp_next;
    logic [OW-1:0]     off_reg, off_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic              chk_reg, chk_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              match_vld_reg, match_vld_next;
    logic [IW-1:0]     match_idx_reg, match_idx_next;
    logic [B-1:0]      pres_reg, pres_next;
    logic [B-1:0]      dirty_reg, dirty_next;
    logic              free_vld_reg, free_vld_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [PW-1:0]     ul_prev_reg, ul_prev_next;
    logic [PW-1:0]     ul_nxt_reg, ul_nxt_next;
    logic [IW-1:0]     tgt_reg, tgt_next;
    logic [IW-1:0]     ev_idx_reg, ev_idx_next;
    logic [6:0]        pop_p_reg, pop_p_next;
    logic [6:0]        pop_d_reg, pop_d_next;
    logic              forced_reg, forced_next;
    logic [8:0]        free_blk_reg, free_blk_next;
    logic [8:0]        groups_reg, groups_next;
    logic [8:0]        destaged_reg, destaged_next;
    logic              hit_reg, hit_next;
    logic              seq_reg, seq_next;

    // RAM ports
    logic              e_we;
    logic [IW-1:0]     e_waddr, e_raddr;
    logic [EW-1:0]     e_wdata, e_rdata;
    logic [1:0]        l_we;
    logic [IW-1:0]     l_waddr, l_raddr;
    logic [2*PW-1:0]   l_wdata, l_rdata;

    // decoded read data and helpers
    logic              e_valid;
    logic [TW-1:0]     e_tag;
    logic [B-1:0]      e_pres, e_dirty;
    logic [PW-1:0]     l_prev, l_nxt;
    logic [B-1:0]      mask;
    logic [B-1:0]      new_pres, new_dirty;
    logic [31:0]       q0, r0, q1, r1;
    logic [8:0]        eff_high, free_dec;
    logic              head_is_match, seq_cond;
    logic [31:0]       grp32;

    assign e_valid = e_rdata[EW-1];
    assign e_tag   = e_rdata[EW-2 -: TW];
    assign e_pres  = e_rdata[2*B-1 -: B];
    assign e_dirty = e_rdata[B-1:0];
    assign l_nxt   = l_rdata[PW-1:0];
    assign l_prev  = l_rdata[2*PW-1 -: PW];

    assign mask      = B'(1) << off_reg;
    assign new_pres  = pres_reg | mask;
    assign new_dirty = rd_reg ? dirty_reg : (dirty_reg | mask);
    assign q0        = prod_reg[SH +: 32];
    assign r0        = blk_reg - q0 * BPG32;
    assign q1        = (r0 >= BPG32) ? q0 + 32'd1 : q0;
    assign r1        = (r0 >= BPG32) ? r0 - BPG32 : r0;
    assign eff_high  = (cfg.high_water < cfg.capacity) ? cfg.high_water : cfg.capacity;
    assign free_dec  = (free_blk_reg == 9'd0) ? 9'd0 : free_blk_reg - 9'd1;
    assign head_is_match = !head_reg[IW] && (head_reg[IW-1:0] == match_idx_reg);
    assign seq_cond  = (new_pres == FULL) && ((new_dirty == '0) || (new_dirty == FULL))
                       && (off_reg == LAST_OFF);
    assign grp32     = 32'(grp_reg);

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.hit                   = hit_reg;
    assign res.sequential_detected   = seq_reg;
    assign res.group_number          = grp32[26:0];
    assign res.groups_evicted        = groups_reg;
    assign res.dirty_blocks_destaged = destaged_reg;

    sgd_ram #(.DEPTH(TABLE_GROUPS), .LANES(1), .LANE_W(EW)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    sgd_ram #(.DEPTH(TABLE_GROUPS), .LANES(2), .LANE_W(PW)) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        blk_next       = blk_reg;
        rd_next        = rd_reg;
        prod_next      = prod_reg;
        grp_next       = grp_reg;
        off_next       = off_reg;
        scan_next      = scan_reg;
        chk_next       = 1'b0;
        chk_idx_next   = chk_idx_reg;
        match_vld_next = match_vld_reg;
        match_idx_next = match_idx_reg;
        pres_next      = pres_reg;
        dirty_next     = dirty_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        ul_prev_next   = ul_prev_reg;
        ul_nxt_next    = ul_nxt_reg;
        tgt_next       = tgt_reg;
        ev_idx_next    = ev_idx_reg;
        pop_p_next     = pop_p_reg;
        pop_d_next     = pop_d_reg;
        forced_next    = forced_reg;
        free_blk_next  = free_blk_reg;
        groups_next    = groups_reg;
        destaged_next  = destaged_reg;
        hit_next       = hit_reg;
        seq_next       = seq_reg;

        e_we    = 1'b0;
        e_waddr = tgt_reg;
        e_wdata = '0;
        e_raddr = scan_reg;
        l_we    = 2'b00;
        l_waddr = tgt_reg;
        l_wdata = {NIL_PTR, NIL_PTR};
        l_raddr = tgt_reg;

        // scan result of the address issued last cycle
        if (chk_reg)
        begin
            if (e_valid && (e_tag == grp_reg))
            begin
                match_vld_next = 1'b1;
                match_idx_next = chk_idx_reg;
                pres_next      = e_pres;
                dirty_next     = e_dirty;
            end
            if (!e_valid && !free_vld_reg)
            begin
                free_vld_next = 1'b1;
                free_idx_next = chk_idx_reg;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                e_we    = 1'b1;
                e_waddr = scan_reg;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    blk_next      = blk;
                    rd_next       = rd;
                    groups_next   = '0;
                    destaged_next = '0;
                    hit_next      = 1'b0;
                    seq_next      = 1'b0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                prod_next  = PRW'(blk_reg) * PRW'(RECIP);
                state_next = S_QUO;
            end
            S_QUO:
            begin
                grp_next       = q1[TW-1:0];
                off_next       = r1[OW-1:0];
                match_vld_next = 1'b0;
                free_vld_next  = 1'b0;
                scan_next      = '0;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                e_raddr      = scan_reg;
                chk_next     = 1'b1;
                chk_idx_next = scan_reg;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                tgt_next = match_idx_reg;
                if (match_vld_reg && ((pres_reg & mask) != '0))
                begin
                    hit_next   = 1'b1;
                    dirty_next = new_dirty;
                    e_we       = 1'b1;
                    e_waddr    = match_idx_reg;
                    e_wdata    = {1'b1, grp_reg, pres_reg, new_dirty};
                    phase_next = PH_HIT;
                    state_next = head_is_match ? S_DONE : S_UL_RD;
                end
                else if (match_vld_reg)
                begin
                    phase_next = PH_MISS;
                    state_next = head_is_match ? S_MISS : S_UL_RD;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_UL_RD:
            begin
                l_raddr    = tgt_reg;
                state_next = S_UL_PREV;
            end
            S_UL_PREV:
            begin
                ul_prev_next = l_prev;
                ul_nxt_next  = l_nxt;
                if (!l_prev[IW])
                begin
                    l_we    = 2'b01;
                    l_waddr = l_prev[IW-1:0];
                    l_wdata = {NIL_PTR, l_nxt};
                end
                else
                begin
                    head_next = l_nxt;
                end
                state_next = S_UL_NEXT;
            end
            S_UL_NEXT:
            begin
                if (!ul_nxt_reg[IW])
                begin
                    l_we    = 2'b10;
                    l_waddr = ul_nxt_reg[IW-1:0];
                    l_wdata = {ul_prev_reg, NIL_PTR};
                end
                else
                begin
                    tail_next = ul_prev_reg;
                end
                state_next = (phase_reg == PH_DROP) ? S_DONE : S_PUSH_SELF;
            end
            S_PUSH_SELF:
            begin
                l_we       = 2'b11;
                l_waddr    = tgt_reg;
                l_wdata    = {NIL_PTR, head_reg};
                state_next = S_PUSH_HEAD;
            end
            S_PUSH_HEAD:
            begin
                if (!head_reg[IW])
                begin
                    l_we    = 2'b10;
                    l_waddr = head_reg[IW-1:0];
                    l_wdata = {1'b0, tgt_reg, NIL_PTR};
                end
                else
                begin
                    tail_next = {1'b0, tgt_reg};
                end
                head_next = {1'b0, tgt_reg};
                case (phase_reg)
                    PH_HIT:  state_next = S_DONE;
                    PH_MISS: state_next = S_MISS;
                    default: state_next = S_INSERT;
                endcase
            end
            S_MISS:
            begin
                forced_next = 1'b0;
                state_next  = (free_blk_reg <= {1'b0, cfg.low_water}) ? S_EV_CHECK : S_ALLOC;
            end
            S_EV_CHECK:
            begin
                state_next = ((free_blk_reg < eff_high) && !tail_reg[IW]) ? S_EV_RD : S_ALLOC;
            end
            S_EV_RD:
            begin
                e_raddr     = tail_reg[IW-1:0];
                l_raddr     = tail_reg[IW-1:0];
                ev_idx_next = tail_reg[IW-1:0];
                state_next  = S_EV_POP;
            end
            S_EV_POP:
            begin
                pop_p_next = popcnt(e_pres);
                pop_d_next = popcnt(e_dirty);
                e_we       = 1'b1;
                e_waddr    = ev_idx_reg;
                if (!l_prev[IW])
                begin
                    l_we    = 2'b01;
                    l_waddr = l_prev[IW-1:0];
                    l_wdata = {NIL_PTR, NIL_PTR};
                end
                else
                begin
                    head_next = NIL_PTR;
                end
                tail_next = l_prev;
                if (match_vld_reg && (match_idx_reg == ev_idx_reg))
                begin
                    match_vld_next = 1'b0;
                end
                if (!free_vld_reg || (ev_idx_reg < free_idx_reg))
                begin
                    free_vld_next = 1'b1;
                    free_idx_next = ev_idx_reg;
                end
                state_next = S_EV_ACC;
            end
            S_EV_ACC:
            begin
                free_blk_next = sat9(free_blk_reg, {2'b00, pop_p_reg});
                destaged_next = sat9(destaged_reg, {2'b00, pop_d_reg});
                groups_next   = sat9(groups_reg, 9'd1);
                state_next    = forced_reg ? S_ALLOC : S_EV_CHECK;
            end
            S_ALLOC:
            begin
                if (match_vld_reg)
                begin
                    tgt_next   = match_idx_reg;
                    state_next = S_INSERT;
                end
                else if (free_vld_reg)
                begin
                    tgt_next   = free_idx_reg;
                    pres_next  = '0;
                    dirty_next = '0;
                    phase_next = PH_NEW;
                    state_next = S_PUSH_SELF;
                end
                else
                begin
                    // table full: evict the LRU group to make room
                    forced_next = 1'b1;
                    state_next  = S_EV_RD;
                end
            end
            S_INSERT:
            begin
                e_we    = 1'b1;
                e_waddr = tgt_reg;
                if (seq_cond)
                begin
                    seq_next      = 1'b1;
                    free_blk_next = sat9(free_dec, BPG9);
                    phase_next    = PH_DROP;
                    state_next    = S_UL_RD;
                end
                else
                begin
                    free_blk_next = free_dec;
                    e_wdata       = {1'b1, grp_reg, new_pres, new_dirty};
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            scan_reg     <= '0;
            chk_reg      <= 1'b0;
            head_reg     <= NIL_PTR;
            tail_reg     <= NIL_PTR;
            free_blk_reg <= sgd_pkg::CAPACITY_RST;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            chk_reg      <= chk_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            free_blk_reg <= free_blk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg     <= phase_next;
        blk_reg       <= blk_next;
        rd_reg        <= rd_next;
        prod_reg      <= prod_next;
        grp_reg       <= grp_next;
        off_reg       <= off_next;
        chk_idx_reg   <= chk_idx_next;
        match_vld_reg <= match_vld_next;
        match_idx_reg <= match_idx_next;
        pres_reg      <= pres_next;
        dirty_reg     <= dirty_next;
        free_vld_reg  <= free_vld_next;
        free_idx_reg  <= free_idx_next;
        ul_prev_reg   <= ul_prev_next;
        ul_nxt_reg    <= ul_nxt_next;
        tgt_reg       <= tgt_next;
        ev_idx_reg    <= ev_idx_next;
        pop_p_reg     <= pop_p_next;
        pop_d_reg     <= pop_d_next;
        forced_reg    <= forced_next;
        groups_reg    <= groups_next;
        destaged_reg  <= destaged_next;
        hit_reg       <= hit_next;
        seq_reg       <= seq_next;
    end

endmodule
`default_nettype wire

### hw/rtl/sequential_group_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_group_detector_top - sequential group detector
// Tracks block requests in aligned groups held in a recency-ordered table
// and reports groups that complete sequentially.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  --------------------------------------------
//  input     in_valid / in_stall    block_number, is_read
//  output    out_valid / out_stall  hit, sequential_detected, group_number,
//                                   groups_evicted, dirty_blocks_destaged
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One request at a time. Each request runs a tag scan of every table entry
//  through the single read port of the entry RAM, which sets the bulk of its
//  time, plus steps to move a group to the front, to evict each group and for
//  the miss check, an insert and a sequential drop.
//  After reset the entry RAM is swept clear entry by entry with in_stall
//  high; configuration writes are taken throughout.
//  A finished result sits in the output register, so the next request is
//  taken while out_stall holds the previous one.
//
module sequential_group_detector_top #(
    parameter int BLOCKS_PER_GROUP = 32,
    parameter int TABLE_GROUPS     = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [31:0] block_number,
    input  wire logic        is_read,
    // result channel
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        hit,
    output      logic        sequential_detected,
    output      logic [26:0] group_number,
    output      logic [8:0]  groups_evicted,
    output      logic [8:0]  dirty_blocks_destaged,
    // configuration channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    sgd_pkg::cfg_t    cfg_reg, cfg_next;
    sgd_pkg::result_t res_reg, res_next;
    sgd_pkg::result_t core_res;
    logic             out_valid_reg, out_valid_next;
    logic             core_busy, core_res_valid, core_res_ready;
    logic             start;

    // accept a request only while the sequencer is idle
    assign in_stall = core_busy;
    assign start    = in_valid && !core_busy;

    // the output register frees up when empty or being drained this cycle
    assign core_res_ready = !out_valid_reg || !out_stall;

    assign cfg_ready = 1'b1;

    sgd_ctrl #(
        .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP),
        .TABLE_GROUPS     (TABLE_GROUPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (start),
        .blk       (block_number),
        .rd        (is_read),
        .busy      (core_busy),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    // register writes; unknown indexes drop silently
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sgd_pkg::CFG_CAPACITY:   cfg_next.capacity   = cfg_data;
                sgd_pkg::CFG_LOW_WATER:  cfg_next.low_water  = cfg_data[7:0];
                sgd_pkg::CFG_HIGH_WATER: cfg_next.high_water = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // hold the result until taken, then load the next one
    always_comb
    begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (core_res_valid && core_res_ready)
        begin
            res_next       = core_res;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity   <= sgd_pkg::CAPACITY_RST;
            cfg_reg.low_water  <= sgd_pkg::LOW_WATER_RST;
            cfg_reg.high_water <= sgd_pkg::HIGH_WATER_RST;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid             = out_valid_reg;
    assign hit                   = res_reg.hit;
    assign sequential_detected   = res_reg.sequential_detected;
    assign group_number          = res_reg.group_number;
    assign groups_evicted        = res_reg.groups_evicted;
    assign dirty_blocks_destaged = res_reg.dirty_blocks_destaged;

endmodule
`default_nettype wire
